// ===== src/ompd_pkg.sv =====
// ----------------------------------------------------------------------------
// ompd_pkg
// Shared types, constants and register indexes for the OOK Manchester
// pulse decoder.
// ----------------------------------------------------------------------------
package ompd_pkg;

  localparam int BUFFER_WORDS_DEF = 8;

  localparam int WIDTH_W    = 16;
  localparam int WORD_W     = 32;
  localparam int PROG_W     = 8;
  localparam int SLOT_W     = 6;
  localparam int IDX_W      = 3;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [PROG_W-1:0] PROGRESS_MAX = 8'd200;
  localparam logic [SLOT_W-1:0] WORD_TOP     = 6'd32;
  localparam logic [7:0]        PREAMBLE_ONES = 8'hFF;

  // limits and reset values of the threshold registers
  localparam logic [WIDTH_W-1:0] MIN_WIDTH_LOW   = 16'd50;
  localparam logic [WIDTH_W-1:0] MIN_WIDTH_HIGH  = 16'hEFFF;
  localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST   = 16'd150;
  localparam logic [WIDTH_W-1:0] SHORT_MAX_RST   = 16'd700;
  localparam logic [WIDTH_W-1:0] LONG_MAX_RST    = 16'd1200;
  localparam logic [WIDTH_W-1:0] END_MIN_RST     = 16'd2500;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MAX_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_MAX_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MIN_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUIRE_PREAMBLE = 3'd4;

  typedef enum logic [1:0] {
    ACT_PULSE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    ST_IGNORED      = 4'd0,
    ST_IDLE         = 4'd1,
    ST_START        = 4'd2,
    ST_LONG         = 4'd3,
    ST_LONG_BIT     = 4'd4,
    ST_SHORT        = 4'd5,
    ST_SHORT_BIT    = 4'd6,
    ST_END          = 4'd7,
    ST_BAD_PREAMBLE = 4'd8,
    ST_ODD          = 4'd9,
    ST_WRONG        = 4'd10,
    ST_TOO_SHORT    = 4'd11
  } status_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] min_width;
    logic [WIDTH_W-1:0] short_max_width;
    logic [WIDTH_W-1:0] long_max_width;
    logic [WIDTH_W-1:0] end_min_width;
    logic               require_preamble;
  } cfg_t;

endpackage

// ===== src/ompd_cfg.sv =====
// ----------------------------------------------------------------------------
// ompd_cfg
// Threshold and option registers with the ordering checks on write.
// ----------------------------------------------------------------------------
module ompd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ompd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ompd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output ompd_pkg::cfg_t                 cfg
);
  import ompd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_WIDTH: begin
          if (cfg_wdata >= MIN_WIDTH_LOW && cfg_wdata <= MIN_WIDTH_HIGH) begin
            cfg_nxt.min_width = cfg_wdata;
          end
        end
        CFG_SHORT_MAX_WIDTH: begin
          if (cfg_wdata > cfg_r.min_width) begin
            cfg_nxt.short_max_width = cfg_wdata;
          end
        end
        CFG_LONG_MAX_WIDTH: begin
          if (cfg_wdata > cfg_r.short_max_width) begin
            cfg_nxt.long_max_width = cfg_wdata;
          end
        end
        CFG_END_MIN_WIDTH: begin
          if (cfg_wdata > cfg_r.long_max_width) begin
            cfg_nxt.end_min_width = cfg_wdata;
          end
        end
        CFG_REQUIRE_PREAMBLE: begin
          cfg_nxt.require_preamble = cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_width        <= MIN_WIDTH_RST;
      cfg_r.short_max_width  <= SHORT_MAX_RST;
      cfg_r.long_max_width   <= LONG_MAX_RST;
      cfg_r.end_min_width    <= END_MIN_RST;
      cfg_r.require_preamble <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/ompd_word_mem.sv =====
// ----------------------------------------------------------------------------
// ompd_word_mem
// Word buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ompd_word_mem #(
  parameter int DEPTH = ompd_pkg::BUFFER_WORDS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [ompd_pkg::WORD_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [ompd_pkg::WORD_W-1:0] rdata
);
  import ompd_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read so a stalled result keeps it
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/ook_manchester_pulse_decoder.sv =====
// ----------------------------------------------------------------------------
// ook_manchester_pulse_decoder
// Manchester decoder for measured OOK pulse widths, with a word buffer.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  action, width, level, word_index
//   out_     output     out_valid/out_stall  status, message_ready,
//                                            word_count, read_word
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// one item per cycle while in_stall is low; each transfer produces its result
// in the output register in the next cycle, and read data comes straight from
// the buffer memory's registered read port in that same cycle.
// in_stall rises only while a result sits in the output register and the
// receiver stalls it; the memory read register holds with it.
// reset (rst_n low, synchronous) clears decoder state, the thresholds and the
// output valid flag; buffer contents are left as they are and are only
// returned once written in the current message.
//
module ook_manchester_pulse_decoder #(
  parameter int BUFFER_WORDS = ompd_pkg::BUFFER_WORDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_action,
  input  logic [ompd_pkg::WIDTH_W-1:0]     in_width,
  input  logic                             in_level,
  input  logic [ompd_pkg::IDX_W-1:0]       in_word_index,

  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [3:0]                       out_status,
  output logic                             out_message_ready,
  output logic [ompd_pkg::COUNT_W-1:0]     out_word_count,
  output logic [ompd_pkg::WORD_W-1:0]      out_read_word,

  input  logic                             cfg_we,
  input  logic [ompd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ompd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ompd_pkg::*;

  localparam int AW   = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;
  localparam int WI_W = $clog2(BUFFER_WORDS + 1);
  localparam int CMP_W = WI_W + IDX_W;
  localparam logic [WI_W-1:0] WI_LAST = WI_W'(BUFFER_WORDS - 1);
  localparam logic [WI_W-1:0] WI_FULL = WI_W'(BUFFER_WORDS);

  cfg_t cfg;

  // decoder state
  logic              active_r,   active_nxt;
  logic              held_r,     held_nxt;
  logic [1:0]        phase_r,    phase_nxt;
  logic [PROG_W-1:0] prog_r,     prog_nxt;
  logic [WORD_W-1:0] partial_r,  partial_nxt;
  logic [SLOT_W-1:0] slot_r,     slot_nxt;
  logic [WI_W-1:0]   wi_r,       wi_nxt;
  logic [7:0]        first_byte_r;

  // output register
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r;
  logic              out_ready_r;
  logic [WI_W-1:0]   out_wi_r;
  logic              rd_hit_r;

  logic              in_fire;
  action_t           act;
  status_t           status;
  logic              clear;
  logic              adv_en;
  logic [1:0]        halves;
  logic [PROG_W:0]   prog_sum;
  logic              store_en;
  logic [WORD_W-1:0] store_data;
  logic [7:0]        check_byte;
  logic              rd_req;
  logic              rd_hit;
  logic              gt_short, le_long, gt_end, gt_min;
  logic [WORD_W-1:0] mem_rdata;

  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;
  assign act      = action_t'(in_action);

  // width windows
  assign gt_min   = in_width > cfg.min_width;
  assign gt_short = in_width > cfg.short_max_width;
  assign le_long  = in_width <= cfg.long_max_width;
  assign gt_end   = in_width > cfg.end_min_width;

  // buffer entry zero only matters for the preamble check; with the write
  // index still at zero the end flush itself fills that entry
  assign check_byte = (wi_r == '0) ? partial_r[WORD_W-1 -: 8] : first_byte_r;

  assign rd_hit = (CMP_W'(in_word_index) < CMP_W'(wi_r)) &&
                  (32'(in_word_index) < 32'(BUFFER_WORDS));

  ompd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ompd_word_mem #(
    .DEPTH (BUFFER_WORDS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (store_en),
    .waddr (AW'(wi_r)),
    .wdata (store_data),
    .re    (rd_req),
    .raddr (AW'(in_word_index)),
    .rdata (mem_rdata)
  );

  // next decoder state and status for the item in transfer
  always_comb begin
    active_nxt  = active_r;
    held_nxt    = held_r;
    phase_nxt   = phase_r;
    prog_nxt    = prog_r;
    partial_nxt = partial_r;
    slot_nxt    = slot_r;
    wi_nxt      = wi_r;
    status      = ST_IGNORED;
    clear       = 1'b0;
    adv_en      = 1'b0;
    halves      = 2'd0;
    prog_sum    = '0;
    store_en    = 1'b0;
    store_data  = partial_r;
    rd_req      = 1'b0;

    if (in_fire) begin
      case (act)
        ACT_PULSE: begin
          if (held_r) begin
            status = ST_IGNORED;
          end else if (!active_r) begin
            // a long low pulse opens a message
            if (gt_short && le_long) begin
              status = ST_IDLE;
              if (!in_level) begin
                active_nxt = 1'b1;
                phase_nxt  = 2'd2;
                prog_nxt   = PROG_W'(2);
                status     = ST_START;
              end
            end
          end else if (gt_short) begin
            if (le_long) begin
              if (phase_r[0]) begin
                status = ST_ODD;
                clear  = 1'b1;
              end else begin
                status = ST_LONG;
                adv_en = 1'b1;
                halves = 2'd2;
              end
            end else if (gt_end && prog_r >= PROGRESS_MAX) begin
              // end of message: flush the partial word and hold
              store_en = (wi_r < WI_FULL);
              wi_nxt   = wi_r + WI_W'(1);
              held_nxt = 1'b1;
              status   = ST_END;
              if (cfg.require_preamble && check_byte != PREAMBLE_ONES) begin
                status = ST_BAD_PREAMBLE;
                clear  = 1'b1;
              end
            end else begin
              status = ST_WRONG;
              clear  = 1'b1;
            end
          end else if (gt_min) begin
            status = ST_SHORT;
            adv_en = 1'b1;
            halves = 2'd1;
          end else begin
            status = ST_TOO_SHORT;
            clear  = 1'b1;
          end
        end
        ACT_READ: begin
          rd_req = 1'b1;
        end
        ACT_CLEAR: begin
          clear = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (adv_en) begin
      phase_nxt = phase_r + halves;
      prog_sum  = {1'b0, prog_r} + (PROG_W+1)'(halves);
      prog_nxt  = (prog_sum > (PROG_W+1)'(PROGRESS_MAX)) ? PROGRESS_MAX : prog_sum[PROG_W-1:0];
      // phase back at zero: sample the level as the next bit
      if (phase_nxt == 2'd0) begin
        if (in_level) begin
          partial_nxt = partial_r | (WORD_W'(1) << (slot_r - SLOT_W'(1)));
        end
        slot_nxt = slot_r - SLOT_W'(1);
        status   = (status == ST_LONG) ? ST_LONG_BIT : ST_SHORT_BIT;
      end
      // full word goes to the buffer, last entry is reused when full
      if (slot_nxt == '0) begin
        store_en    = (wi_r < WI_FULL);
        store_data  = partial_nxt;
        partial_nxt = '0;
        slot_nxt    = WORD_TOP;
        wi_nxt      = (wi_r + WI_W'(1) >= WI_FULL) ? WI_LAST : wi_r + WI_W'(1);
      end
    end

    if (clear) begin
      active_nxt  = 1'b0;
      held_nxt    = 1'b0;
      phase_nxt   = 2'd0;
      prog_nxt    = '0;
      partial_nxt = '0;
      slot_nxt    = WORD_TOP;
      wi_nxt      = '0;
    end
  end

  assign out_valid_nxt = in_fire | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      held_r      <= 1'b0;
      phase_r     <= 2'd0;
      prog_r      <= '0;
      partial_r   <= '0;
      slot_r      <= WORD_TOP;
      wi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      held_r      <= held_nxt;
      phase_r     <= phase_nxt;
      prog_r      <= prog_nxt;
      partial_r   <= partial_nxt;
      slot_r      <= slot_nxt;
      wi_r        <= wi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // shadow of the top byte of buffer entry zero
  always_ff @(posedge clk) begin
    if (store_en && wi_r == '0) begin
      first_byte_r <= store_data[WORD_W-1 -: 8];
    end
  end

  // result payload, loaded on transfer only
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r <= status;
      out_ready_r  <= held_nxt;
      out_wi_r     <= wi_nxt;
      rd_hit_r     <= rd_req & rd_hit;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_message_ready = out_ready_r;
  assign out_word_count    = COUNT_W'(out_wi_r);
  assign out_read_word     = rd_hit_r ? mem_rdata : '0;

`ifndef NO_ASSERTIONS
  // write index stays inside the buffer unless a message is held
  a_wi_range: assert property (@(posedge clk) disable iff (!rst_n)
    !held_r |-> (wi_r <= WI_LAST))
    else $error("write index beyond buffer while no message held");

  // a held message is always an active one
  a_held_active: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> active_r)
    else $error("message held while decoder idle");

  // idle decoder carries no progress and an empty partial word
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (prog_r == '0 && slot_r == WORD_TOP && partial_r == '0))
    else $error("idle decoder with leftover state");

  // bit slot never reaches zero between items
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_r != '0) && (slot_r <= WORD_TOP))
    else $error("bit slot out of range");

  // progress saturates
  a_prog_sat: assert property (@(posedge clk) disable iff (!rst_n)
    prog_r <= PROGRESS_MAX)
    else $error("half progress above limit");
`endif

endmodule

// ===== verif/ompd_decode_checker.sv =====
// ----------------------------------------------------------------------------
// ompd_decode_checker
// Watches the pulse, result and register ports of the OOK Manchester pulse
// decoder, predicts every result from its own copy of the decoder state and
// compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module ompd_decode_checker #(
  parameter int BUFFER_WORDS = ompd_pkg::BUFFER_WORDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [1:0]                       in_action,
  input  logic [ompd_pkg::WIDTH_W-1:0]     in_width,
  input  logic                             in_level,
  input  logic [ompd_pkg::IDX_W-1:0]       in_word_index,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [3:0]                       out_status,
  input  logic                             out_message_ready,
  input  logic [ompd_pkg::COUNT_W-1:0]     out_word_count,
  input  logic [ompd_pkg::WORD_W-1:0]      out_read_word,
  input  logic                             cfg_we,
  input  logic [ompd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ompd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                               failures,
  output int                               waiting
);
  import ompd_pkg::*;

  typedef struct packed {
    status_t              status;
    logic                 ready;
    logic [COUNT_W-1:0]   count;
    logic [WORD_W-1:0]    word;
  } decode_result_t;

  // thresholds
  logic [WIDTH_W-1:0] th_min, th_short, th_long, th_end;
  logic               need_ones;

  // decoder state
  logic               active_q;
  logic [1:0]         phase_q;
  logic [PROG_W-1:0]  progress_q;
  logic               held_q;
  logic [WORD_W-1:0]  partial_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [COUNT_W-1:0] widx_q;
  logic [WORD_W-1:0]  store_q [BUFFER_WORDS];

  decode_result_t pending_results[$];
  int mismatch_count = 0;

  assign failures = mismatch_count;

  task automatic restart_decoder();
    active_q   = 1'b0;
    phase_q    = 2'd0;
    progress_q = '0;
    held_q     = 1'b0;
    partial_q  = '0;
    slot_q     = WORD_TOP;
    widx_q     = '0;
  endtask

  task automatic add_halves(input int halves, input logic lvl, output logic took_bit);
    int prog;
    phase_q = phase_q + halves[1:0];
    prog = progress_q + halves;
    progress_q = (prog > PROGRESS_MAX) ? PROGRESS_MAX : prog[PROG_W-1:0];
    took_bit = (phase_q == 2'd0);
    if (took_bit && slot_q >= 1 && slot_q <= WORD_TOP) begin
      if (lvl) partial_q[slot_q - 1] = 1'b1;
      slot_q = slot_q - 1'b1;
    end
  endtask

  task automatic decode_pulse(input logic [WIDTH_W-1:0] w, input logic lvl,
                              output status_t st);
    logic took_bit;
    st = ST_IGNORED;
    if (held_q) return;
    if (!active_q) begin
      // idle: only a long pulse matters, and only a low one starts
      if (w > th_short && w <= th_long) begin
        st = ST_IDLE;
        if (!lvl) begin
          active_q   = 1'b1;
          phase_q    = 2'd2;
          progress_q = 8'd2;
          st         = ST_START;
        end
      end
      return;
    end
    if (w > th_short) begin
      if (w <= th_long) begin
        if (phase_q[0]) begin
          st = ST_ODD;
          restart_decoder();
        end else begin
          add_halves(2, lvl, took_bit);
          st = took_bit ? ST_LONG_BIT : ST_LONG;
        end
      end else if (w > th_end && progress_q >= PROGRESS_MAX) begin
        // end of message: flush the partial word and hold
        if (slot_q != 0) begin
          if (widx_q < BUFFER_WORDS) store_q[widx_q] = partial_q;
          widx_q = widx_q + 1'b1;
        end
        held_q = 1'b1;
        st = ST_END;
        if (need_ones && store_q[0][WORD_W-1 -: 8] != PREAMBLE_ONES) begin
          st = ST_BAD_PREAMBLE;
          restart_decoder();
        end
      end else begin
        st = ST_WRONG;
        restart_decoder();
      end
    end else if (w > th_min) begin
      add_halves(1, lvl, took_bit);
      st = took_bit ? ST_SHORT_BIT : ST_SHORT;
    end else begin
      st = ST_TOO_SHORT;
      restart_decoder();
    end
    // full word goes to the buffer, index sticks at the last entry
    if (slot_q == 0) begin
      if (widx_q < BUFFER_WORDS) store_q[widx_q] = partial_q;
      partial_q = '0;
      slot_q = WORD_TOP;
      widx_q = widx_q + 1'b1;
      if (widx_q >= BUFFER_WORDS) widx_q = COUNT_W'(BUFFER_WORDS - 1);
    end
  endtask

  task automatic note_mismatch(input string what, input logic [WORD_W-1:0] want_v,
                               input logic [WORD_W-1:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want_v, got_v);
  endtask

  always @(posedge clk) begin : watch
    decode_result_t want;
    status_t st;
    logic [WORD_W-1:0] rd;
    if (!rst_n) begin
      th_min    = MIN_WIDTH_RST;
      th_short  = SHORT_MAX_RST;
      th_long   = LONG_MAX_RST;
      th_end    = END_MIN_RST;
      need_ones = 1'b0;
      restart_decoder();
      pending_results.delete();
    end else begin
      // result transfer against the oldest prediction
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_results.size() == 0) begin
          note_mismatch("unexpected result, status", '0, WORD_W'(out_status));
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status)
            note_mismatch("status", WORD_W'(want.status), WORD_W'(out_status));
          if (out_message_ready !== want.ready)
            note_mismatch("message_ready", WORD_W'(want.ready), WORD_W'(out_message_ready));
          if (out_word_count !== want.count)
            note_mismatch("word_count", WORD_W'(want.count), WORD_W'(out_word_count));
          if (out_read_word !== want.word)
            note_mismatch("read_word", want.word, out_read_word);
        end
      end

      if (cfg_we === 1'b1) begin
        case (cfg_index)
          CFG_MIN_WIDTH:
            if (cfg_wdata >= MIN_WIDTH_LOW && cfg_wdata <= MIN_WIDTH_HIGH) th_min = cfg_wdata;
          CFG_SHORT_MAX_WIDTH:  if (cfg_wdata > th_min) th_short = cfg_wdata;
          CFG_LONG_MAX_WIDTH:   if (cfg_wdata > th_short) th_long = cfg_wdata;
          CFG_END_MIN_WIDTH:    if (cfg_wdata > th_long) th_end = cfg_wdata;
          CFG_REQUIRE_PREAMBLE: need_ones = cfg_wdata[0];
          default: ;
        endcase
      end

      // input transfer: predict its result
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        st = ST_IGNORED;
        rd = '0;
        case (in_action)
          ACT_PULSE: decode_pulse(in_width, in_level, st);
          ACT_READ:
            if (in_word_index < widx_q && in_word_index < BUFFER_WORDS)
              rd = store_q[in_word_index];
          ACT_CLEAR: restart_decoder();
          default: ;
        endcase
        want.status = st;
        want.ready  = held_q;
        want.count  = widx_q;
        want.word   = rd;
        pending_results.push_back(want);
      end
    end
    waiting = pending_results.size();
  end

endmodule

// ===== verif/ook_manchester_pulse_decoder_test.sv =====
// ----------------------------------------------------------------------------
// ook_manchester_pulse_decoder_test
// Drives pulse, read and clear transfers into the OOK Manchester pulse
// decoder: a directed opener, then well-formed messages with random content
// mixed with noise and broken sequences, over several threshold settings and
// idle/stall patterns. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module ook_manchester_pulse_decoder_test;
  import ompd_pkg::*;

  // action code outside the defined set, must be ignored
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic [1:0]            in_action     = ACT_PULSE;
  logic [WIDTH_W-1:0]    in_width      = '0;
  logic                  in_level      = 1'b0;
  logic [IDX_W-1:0]      in_word_index = '0;
  logic                  out_stall     = 1'b0;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = CFG_MIN_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

  logic                  in_stall;
  logic                  out_valid;
  logic [3:0]            out_status;
  logic                  out_message_ready;
  logic [COUNT_W-1:0]    out_word_count;
  logic [WORD_W-1:0]     out_read_word;

  int failures;
  int waiting;

  // idle and stall chances in percent, changed per phase
  int idle_pct  = 0;
  int stall_pct = 0;
  int items_sent = 0;

  // thresholds as last written, used to shape pulse widths
  int t_min   = MIN_WIDTH_RST;
  int t_short = SHORT_MAX_RST;
  int t_long  = LONG_MAX_RST;
  int t_end   = END_MIN_RST;

  ook_manchester_pulse_decoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_width          (in_width),
    .in_level          (in_level),
    .in_word_index     (in_word_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_message_ready (out_message_ready),
    .out_word_count    (out_word_count),
    .out_read_word     (out_read_word),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  ompd_decode_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_width          (in_width),
    .in_level          (in_level),
    .in_word_index     (in_word_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_message_ready (out_message_ready),
    .out_word_count    (out_word_count),
    .out_read_word     (out_read_word),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .failures          (failures),
    .waiting           (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver stalls at random, one decision per cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // boundaries are hit a quarter of the time each
  function automatic int pick(input int lo, input int hi);
    int r;
    r = $urandom_range(3);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(hi, lo);
  endfunction

  function automatic int short_w();
    return pick(t_min + 1, t_short);
  endfunction

  function automatic int long_w();
    return pick(t_short + 1, t_long);
  endfunction

  // one input transfer; entered and left at a falling edge
  task automatic send_item(input logic [1:0] act, input int w, input logic lvl,
                           input int idx);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_width      <= w[WIDTH_W-1:0];
    in_level      <= lvl;
    in_word_index <= idx[IDX_W-1:0];
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // stop sending and let every result drain before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_thresholds(input int mn, input int sh, input int lg, input int en);
    // open the upper registers first so each later write is above its neighbor
    write_reg(CFG_END_MIN_WIDTH, 16'hFFFF);
    write_reg(CFG_LONG_MAX_WIDTH, 16'hFFFE);
    write_reg(CFG_SHORT_MAX_WIDTH, 16'hFFFD);
    write_reg(CFG_MIN_WIDTH, CFG_DATA_W'(mn));
    write_reg(CFG_SHORT_MAX_WIDTH, CFG_DATA_W'(sh));
    write_reg(CFG_LONG_MAX_WIDTH, CFG_DATA_W'(lg));
    write_reg(CFG_END_MIN_WIDTH, CFG_DATA_W'(en));
    t_min   = mn;
    t_short = sh;
    t_long  = lg;
    t_end   = en;
  endtask

  task automatic send_noise(input int n);
    repeat (n)
      send_item(2'($urandom_range(3)), $urandom_range(65535), 1'($urandom_range(1)),
                $urandom_range(7));
  endtask

  // a well-formed message: start, half-time pulses up to nbits bits, end,
  // a few reads and usually a clear; a rare broken pulse derails it
  task automatic run_message(input int nbits, input int long_pct);
    int ph;
    int bits;
    int h;
    logic lvl;
    logic want_ones;
    want_ones = ($urandom_range(3) != 0);
    send_item(ACT_PULSE, long_w(), 1'b0, $urandom_range(7));
    ph = 2;
    bits = 0;
    while (bits < nbits) begin
      if ($urandom_range(149) == 0) begin
        case ($urandom_range(2))
          0: send_item(ACT_PULSE, pick(0, t_min), $urandom_range(1), $urandom_range(7));
          1: send_item(ACT_PULSE, pick(t_long + 1, t_end), $urandom_range(1), $urandom_range(7));
          default: send_item(ACT_PULSE, long_w(), $urandom_range(1), $urandom_range(7));
        endcase
      end
      // odd phase only allows a short pulse
      h = (ph % 2 == 1 || $urandom_range(99) >= long_pct) ? 1 : 2;
      ph = (ph + h) % 4;
      lvl = $urandom_range(1);
      if (ph == 0 && bits < 8 && want_ones) lvl = 1'b1;
      send_item(ACT_PULSE, (h == 1) ? short_w() : long_w(), lvl, $urandom_range(7));
      if (ph == 0) bits++;
    end
    send_item(ACT_PULSE, pick(t_end + 1, 65535), $urandom_range(1), $urandom_range(7));
    // pulse while the message is held
    if ($urandom_range(3) == 0)
      send_item(ACT_PULSE, $urandom_range(65535), $urandom_range(1), $urandom_range(7));
    repeat ($urandom_range(4, 1))
      send_item(ACT_READ, $urandom_range(65535), $urandom_range(1), $urandom_range(7));
    if ($urandom_range(11) != 0)
      send_item(ACT_CLEAR, $urandom_range(65535), $urandom_range(1), $urandom_range(7));
  endtask

  task automatic run_phase(input int mn, input int sh, input int lg, input int en,
                           input logic pre, input int idle, input int stall,
                           input logic fill_buffer);
    int r;
    int nbits;
    settle();
    set_thresholds(mn, sh, lg, en);
    write_reg(CFG_REQUIRE_PREAMBLE, {15'd0, pre});
    idle_pct  = idle;
    stall_pct = stall;
    items_sent = 0;
    // more than eight words: index saturates, then the end flush overwrites
    if (fill_buffer) run_message(262, 90);
    while (items_sent < 190) begin
      if ($urandom_range(3) == 0) send_noise($urandom_range(3, 1));
      r = $urandom_range(9);
      // 49 bits ends four half-times short of the minimum, 50 just makes it
      case (r)
        0: nbits = 49;
        1: nbits = 50;
        2: nbits = $urandom_range(48, 20);
        default: nbits = $urandom_range(90, 51);
      endcase
      run_message(nbits, $urandom_range(80, 20));
    end
  endtask

  initial begin : stimulus
    int mn;
    int sh;
    int lg;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed opener at reset thresholds
    send_item(ACT_READ, 0, 1'b0, 0);              // empty buffer reads zero
    send_item(ACT_UNUSED, 65535, 1'b1, 7);        // unknown action
    send_item(ACT_PULSE, 700, 1'b0, 0);           // idle, below long window
    send_item(ACT_PULSE, 1200, 1'b1, 0);          // idle long high
    send_item(ACT_PULSE, 1201, 1'b0, 0);          // idle, above long window
    send_item(ACT_PULSE, 701, 1'b0, 0);           // start
    send_item(ACT_PULSE, 151, 1'b1, 0);           // short, odd phase
    send_item(ACT_PULSE, 1200, 1'b0, 0);          // long at odd phase
    send_item(ACT_PULSE, 1200, 1'b0, 0);          // start
    send_item(ACT_PULSE, 150, 1'b1, 0);           // too short
    send_item(ACT_PULSE, 900, 1'b0, 0);
    send_item(ACT_PULSE, 2500, 1'b1, 0);          // over-long, not yet an end
    send_item(ACT_PULSE, 900, 1'b0, 0);
    send_item(ACT_PULSE, 65535, 1'b0, 0);         // end pulse far too early
    send_item(ACT_PULSE, 900, 1'b0, 0);
    send_item(ACT_PULSE, 700, 1'b1, 0);
    send_item(ACT_CLEAR, 0, 1'b0, 0);
    send_item(ACT_READ, 0, 1'b0, 7);

    // register writes that must be dropped
    settle();
    write_reg(CFG_MIN_WIDTH, MIN_WIDTH_LOW - 1);
    write_reg(CFG_MIN_WIDTH, MIN_WIDTH_HIGH + 1);
    write_reg(CFG_SHORT_MAX_WIDTH, MIN_WIDTH_RST);
    write_reg(CFG_LONG_MAX_WIDTH, SHORT_MAX_RST);
    write_reg(CFG_END_MIN_WIDTH, LONG_MAX_RST);
    for (int i = CFG_REQUIRE_PREAMBLE + 1; i < 8; i++) write_reg(i[CFG_IDX_W-1:0], 16'hFFFF);
    write_reg(CFG_REQUIRE_PREAMBLE, 16'hFFFE);
    send_item(ACT_PULSE, 701, 1'b0, 0);
    send_item(ACT_PULSE, 151, 1'b0, 0);
    send_item(ACT_PULSE, 150, 1'b0, 0);

    // random phases, one idle/stall pattern and threshold set each
    run_phase(MIN_WIDTH_RST, SHORT_MAX_RST, LONG_MAX_RST, END_MIN_RST, 1'b1, 0, 0, 1'b0);
    run_phase(50, 51, 52, 53, 1'b0, 88, 0, 1'b0);
    run_phase(61439, 61440, 65000, 65534, 1'b1, 0, 88, 1'b0);
    run_phase(300, 900, 1800, 4000, 1'b0, 17, 17, 1'b1);
    mn = $urandom_range(2000, 50);
    sh = mn + $urandom_range(3000, 1);
    lg = sh + $urandom_range(3000, 1);
    run_phase(mn, sh, lg, lg + $urandom_range(5000, 1), $urandom_range(1), 0, 0, 1'b0);

    settle();
    repeat (4) @(negedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
